// File: rtl/stcal_pkg.sv
`default_nettype none

package stcal_pkg;

    localparam int RAW_W   = 12;
    localparam int AXIS_W  = 10;
    localparam int LEVEL_W = 11;
    localparam int STEP_W  = 6;
    localparam int KEY_W   = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int FULL_SCALE = 1000;
    localparam int CENTRE     = 500;
    localparam int TRIM_LIMIT = 500;

    typedef logic [RAW_W-1:0]          raw_t;
    typedef logic [AXIS_W-1:0]         axis_t;
    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [STEP_W-1:0]         step_t;
    typedef logic [KEY_W-1:0]          key_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [DATA_W-1:0]         data_t;

    localparam step_t TRIM_STEP_RESET = 6'd5;

    localparam logic REG_TRIM_STEP = 1'b0;

    localparam key_t KEY_NONE       = 3'd0;
    localparam key_t KEY_CALIBRATE  = 3'd1;
    localparam key_t KEY_PITCH_UP   = 3'd2;
    localparam key_t KEY_PITCH_DOWN = 3'd3;
    localparam key_t KEY_ROLL_RIGHT = 3'd4;
    localparam key_t KEY_ROLL_LEFT  = 3'd5;
    localparam key_t KEY_SHUTDOWN   = 3'd6;
    localparam key_t KEY_HOLD       = 3'd7;

    typedef struct packed {
        raw_t raw_pitch;
        raw_t raw_roll;
        raw_t raw_yaw;
        raw_t raw_throttle;
        key_t key_code;
        logic tx_acked;
    } req_t;

    typedef struct packed {
        axis_t pitch_out;
        axis_t roll_out;
        axis_t yaw_out;
        axis_t throttle_out;
        logic  shutdown_flag;
        logic  hold_flag;
    } rsp_t;

    typedef struct packed {
        axis_t pitch;
        axis_t roll;
        axis_t yaw;
        axis_t throttle;
    } scaled_t;

endpackage

`default_nettype wire

// File: rtl/stick_condition_with_trim_calibration_unit.sv
`default_nettype none

// Stick conditioning unit: each request carries four raw stick samples, a key code and
// the radio acknowledge, and produces one response with the four commands in 0..1000
// and the shutdown and hold flags. A request is taken into an input register, and as it
// moves on to the response register the four scalers (one constant reciprocal
// multiplier per axis), the offset and trim adders and the key-driven state update all
// complete combinationally on the way. The unit thus takes one request every clock
// cycle while responses are taken; a response waits in the response register, and a
// stalled response holds the pipeline. The trim step register is written over the APB
// port and should only be changed while no request is in flight.
module stick_condition_with_trim_calibration_unit #(
    parameter int unsigned SAMPLE_MAX = 4095
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  stcal_pkg::req_t   req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output stcal_pkg::rsp_t   res_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  stcal_pkg::addr_t  paddr,
    input  stcal_pkg::data_t  pwdata,
    output stcal_pkg::data_t  prdata,
    output logic              pready
);
    import stcal_pkg::*;

    req_t    hold_reg;
    req_t    hold_next;
    logic    stage_valid_reg;
    logic    stage_valid_next;
    rsp_t    res_data_reg;
    rsp_t    res_data_next;
    logic    res_valid_reg;
    logic    res_valid_next;

    logic    advance;
    logic    req_fire;
    scaled_t scaled;
    rsp_t    rsp;
    step_t   trim_step;

    assign advance   = stage_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !stage_valid_reg || advance;
    assign req_fire  = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    stcal_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .trim_step (trim_step)
    );

    stcal_scaler #(.SAMPLE_MAX(SAMPLE_MAX)) u_scale_pitch (
        .raw    (hold_reg.raw_pitch),
        .invert (1'b1),
        .scaled (scaled.pitch)
    );

    stcal_scaler #(.SAMPLE_MAX(SAMPLE_MAX)) u_scale_roll (
        .raw    (hold_reg.raw_roll),
        .invert (1'b1),
        .scaled (scaled.roll)
    );

    stcal_scaler #(.SAMPLE_MAX(SAMPLE_MAX)) u_scale_yaw (
        .raw    (hold_reg.raw_yaw),
        .invert (1'b0),
        .scaled (scaled.yaw)
    );

    stcal_scaler #(.SAMPLE_MAX(SAMPLE_MAX)) u_scale_throttle (
        .raw    (hold_reg.raw_throttle),
        .invert (1'b1),
        .scaled (scaled.throttle)
    );

    stcal_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .scaled    (scaled),
        .key       (hold_reg.key_code),
        .ack       (hold_reg.tx_acked),
        .trim_step (trim_step),
        .rsp       (rsp)
    );

    always_comb
    begin
        hold_next        = req_fire ? req_data : hold_reg;
        stage_valid_next = req_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
        res_data_next    = advance ? rsp : res_data_reg;
        res_valid_next   = advance ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        res_data_reg <= res_data_next;
    end

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_data_reg.pitch_out <= AXIS_W'(FULL_SCALE))
        && (res_data_reg.roll_out <= AXIS_W'(FULL_SCALE))
        && (res_data_reg.yaw_out <= AXIS_W'(FULL_SCALE))
        && (res_data_reg.throttle_out <= AXIS_W'(FULL_SCALE)))
        else $error("response command out of range");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> req_ready)
        else $error("empty input stage refused a request");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("request left the input stage without a response");

endmodule

`default_nettype wire

// File: rtl/stcal_scaler.sv
`default_nettype none

module stcal_scaler #(
    parameter int unsigned SAMPLE_MAX = 4095
) (
    input  stcal_pkg::raw_t  raw,
    input  logic             invert,
    output stcal_pkg::axis_t scaled
);
    import stcal_pkg::*;

    localparam longint unsigned MAX_L = longint'(SAMPLE_MAX);
    localparam int unsigned     V_W   = $clog2(MAX_L + 1);
    localparam int unsigned     SHIFT = $clog2(MAX_L * MAX_L + 1);
    localparam longint unsigned RECIP =
        ((longint'(FULL_SCALE) << SHIFT) + MAX_L - 1) / MAX_L;
    localparam int unsigned     C_W   = $clog2(RECIP + 1);
    localparam int unsigned     P_W   = V_W + C_W;

    logic [V_W-1:0] sat;
    logic [V_W-1:0] val;
    logic [P_W-1:0] prod;

    // The reciprocal is rounded up with enough fraction bits that the
    // truncated product equals the exact truncating quotient.
    always_comb
    begin
        if (32'(raw) > SAMPLE_MAX)
        begin
            sat = V_W'(SAMPLE_MAX);
        end
        else
        begin
            sat = V_W'(raw);
        end
        if (invert)
        begin
            val = V_W'(SAMPLE_MAX) - sat;
        end
        else
        begin
            val = sat;
        end
        prod   = P_W'(val) * P_W'(RECIP);
        scaled = prod[SHIFT +: AXIS_W];
    end

endmodule

`default_nettype wire

// File: rtl/stcal_cfg.sv
`default_nettype none

module stcal_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  stcal_pkg::addr_t   paddr,
    input  stcal_pkg::data_t   pwdata,
    output stcal_pkg::data_t   prdata,
    output logic               pready,
    output stcal_pkg::step_t   trim_step
);
    import stcal_pkg::*;

    step_t trim_step_reg;
    step_t trim_step_next;
    logic  reg_index;

    assign reg_index = paddr[ADDR_W-1];
    assign pready    = 1'b1;
    assign trim_step = trim_step_reg;

    always_comb
    begin
        trim_step_next = trim_step_reg;
        if (psel && penable && pwrite && pready && (reg_index == REG_TRIM_STEP))
        begin
            trim_step_next = pwdata[STEP_W-1:0];
        end
        if (reg_index == REG_TRIM_STEP)
        begin
            prdata = DATA_W'(trim_step_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_step_reg <= TRIM_STEP_RESET;
        end
        else
        begin
            trim_step_reg <= trim_step_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stcal_state.sv
`default_nettype none

module stcal_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  stcal_pkg::scaled_t  scaled,
    input  stcal_pkg::key_t     key,
    input  logic                ack,
    input  stcal_pkg::step_t    trim_step,
    output stcal_pkg::rsp_t     rsp
);
    import stcal_pkg::*;

    typedef logic signed [LEVEL_W+1:0] sum_t;
    typedef logic signed [STEP_W:0]    delta_t;

    level_t pitch_bias_reg, pitch_bias_next;
    level_t roll_bias_reg, roll_bias_next;
    level_t yaw_bias_reg, yaw_bias_next;
    level_t throttle_bias_reg, throttle_bias_next;
    level_t pitch_trim_reg, pitch_trim_next;
    level_t roll_trim_reg, roll_trim_next;
    logic   shutdown_reg, shutdown_next;
    logic   hold_reg, hold_next;

    delta_t step_up;
    delta_t step_down;

    function automatic axis_t clamp_axis(input sum_t v);
        axis_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > sum_t'(FULL_SCALE))
        begin
            r = AXIS_W'(FULL_SCALE);
        end
        else
        begin
            r = v[AXIS_W-1:0];
        end
        return r;
    endfunction

    function automatic level_t trim_move(input level_t t, input delta_t d);
        logic signed [LEVEL_W:0] s;
        level_t r;
        s = (LEVEL_W + 1)'(t) + (LEVEL_W + 1)'(d);
        if (s > (LEVEL_W + 1)'(TRIM_LIMIT))
        begin
            r = level_t'(TRIM_LIMIT);
        end
        else if (s < -(LEVEL_W + 1)'(TRIM_LIMIT))
        begin
            r = -level_t'(TRIM_LIMIT);
        end
        else
        begin
            r = s[LEVEL_W-1:0];
        end
        return r;
    endfunction

    function automatic sum_t widen(input axis_t a);
        return sum_t'({1'b0, a});
    endfunction

    function automatic level_t level_of(input axis_t a);
        return level_t'({1'b0, a});
    endfunction

    assign step_up   = delta_t'({1'b0, trim_step});
    assign step_down = -step_up;

    always_comb
    begin
        rsp.pitch_out    = clamp_axis(widen(scaled.pitch) - sum_t'(pitch_bias_reg)
                                      + sum_t'(pitch_trim_reg));
        rsp.roll_out     = clamp_axis(widen(scaled.roll) - sum_t'(roll_bias_reg)
                                      + sum_t'(roll_trim_reg));
        rsp.yaw_out      = clamp_axis(widen(scaled.yaw) - sum_t'(yaw_bias_reg));
        rsp.throttle_out = clamp_axis(widen(scaled.throttle) - sum_t'(throttle_bias_reg));

        pitch_bias_next    = pitch_bias_reg;
        roll_bias_next     = roll_bias_reg;
        yaw_bias_next      = yaw_bias_reg;
        throttle_bias_next = throttle_bias_reg;
        pitch_trim_next    = pitch_trim_reg;
        roll_trim_next     = roll_trim_reg;
        shutdown_next      = ack ? 1'b0 : shutdown_reg;
        hold_next          = hold_reg;

        case (key)
            KEY_CALIBRATE:
            begin
                pitch_bias_next    = level_of(scaled.pitch) - level_t'(CENTRE);
                roll_bias_next     = level_of(scaled.roll) - level_t'(CENTRE);
                yaw_bias_next      = level_of(scaled.yaw) - level_t'(CENTRE);
                throttle_bias_next = level_of(scaled.throttle);
            end
            KEY_PITCH_UP:   pitch_trim_next = trim_move(pitch_trim_reg, step_up);
            KEY_PITCH_DOWN: pitch_trim_next = trim_move(pitch_trim_reg, step_down);
            KEY_ROLL_RIGHT: roll_trim_next  = trim_move(roll_trim_reg, step_up);
            KEY_ROLL_LEFT:  roll_trim_next  = trim_move(roll_trim_reg, step_down);
            KEY_SHUTDOWN:   shutdown_next   = 1'b1;
            KEY_HOLD:       hold_next       = ~hold_reg;
            default:
            begin
            end
        endcase

        rsp.shutdown_flag = shutdown_next;
        rsp.hold_flag     = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_bias_reg    <= '0;
            roll_bias_reg     <= '0;
            yaw_bias_reg      <= '0;
            throttle_bias_reg <= '0;
            pitch_trim_reg    <= '0;
            roll_trim_reg     <= '0;
            shutdown_reg      <= 1'b0;
            hold_reg          <= 1'b0;
        end
        else if (advance)
        begin
            pitch_bias_reg    <= pitch_bias_next;
            roll_bias_reg     <= roll_bias_next;
            yaw_bias_reg      <= yaw_bias_next;
            throttle_bias_reg <= throttle_bias_next;
            pitch_trim_reg    <= pitch_trim_next;
            roll_trim_reg     <= roll_trim_next;
            shutdown_reg      <= shutdown_next;
            hold_reg          <= hold_next;
        end
    end

    a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_trim_reg <= level_t'(TRIM_LIMIT)) && (pitch_trim_reg >= -level_t'(TRIM_LIMIT))
        && (roll_trim_reg <= level_t'(TRIM_LIMIT)) && (roll_trim_reg >= -level_t'(TRIM_LIMIT)))
        else $error("trim left its limits");

    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ack && (key != KEY_SHUTDOWN) |=> !shutdown_reg)
        else $error("acknowledge did not clear the shutdown request");

    a_hold_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (key == KEY_HOLD) |=> hold_reg != $past(hold_reg))
        else $error("hold key did not toggle hold mode");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

import stcal_pkg::*;

class command_checker;
    localparam int unsigned SAMPLE_LIMIT = 4095;

    step_t  trim_step;
    level_t pitch_bias;
    level_t roll_bias;
    level_t yaw_bias;
    level_t throttle_bias;
    level_t pitch_trim;
    level_t roll_trim;
    logic   shutdown_req;
    logic   hold_mode;
    rsp_t   expected_commands[$];
    int     mismatches;

    function new();
        trim_step     = TRIM_STEP_RESET;
        pitch_bias    = '0;
        roll_bias     = '0;
        yaw_bias      = '0;
        throttle_bias = '0;
        pitch_trim    = '0;
        roll_trim     = '0;
        shutdown_req  = 1'b0;
        hold_mode     = 1'b0;
        mismatches    = 0;
    endfunction

    function void set_trim_step(step_t s);
        trim_step = s;
    endfunction

    function int pending();
        return expected_commands.size();
    endfunction

    function void compare(string field, int exp, int act);
        if (exp != act)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", field, exp, act);
        end
    endfunction

    function axis_t scale_sample(raw_t raw, bit invert);
        int unsigned v;
        v = raw;
        if (v > SAMPLE_LIMIT)
            v = SAMPLE_LIMIT;
        if (invert)
            v = SAMPLE_LIMIT - v;
        return axis_t'((v * 1000) / SAMPLE_LIMIT);
    endfunction

    function axis_t clamp_command(int v);
        if (v < 0)
            return '0;
        if (v > FULL_SCALE)
            return axis_t'(FULL_SCALE);
        return axis_t'(v);
    endfunction

    function level_t step_trim(level_t t, int delta);
        int r;
        r = int'(t) + delta;
        if (r > TRIM_LIMIT)
            r = TRIM_LIMIT;
        if (r < -TRIM_LIMIT)
            r = -TRIM_LIMIT;
        return level_t'(r);
    endfunction

    function void take_request(req_t r);
        axis_t sp;
        axis_t sr;
        axis_t sy;
        axis_t st;
        rsp_t  c;
        sp = scale_sample(r.raw_pitch, 1'b1);
        sr = scale_sample(r.raw_roll, 1'b1);
        sy = scale_sample(r.raw_yaw, 1'b0);
        st = scale_sample(r.raw_throttle, 1'b1);
        c.pitch_out    = clamp_command(int'(sp) - int'(pitch_bias) + int'(pitch_trim));
        c.roll_out     = clamp_command(int'(sr) - int'(roll_bias) + int'(roll_trim));
        c.yaw_out      = clamp_command(int'(sy) - int'(yaw_bias));
        c.throttle_out = clamp_command(int'(st) - int'(throttle_bias));
        if (r.tx_acked)
            shutdown_req = 1'b0;
        case (r.key_code)
            KEY_CALIBRATE:
            begin
                pitch_bias    = level_t'(int'(sp) - CENTRE);
                roll_bias     = level_t'(int'(sr) - CENTRE);
                yaw_bias      = level_t'(int'(sy) - CENTRE);
                throttle_bias = level_t'(int'(st));
            end
            KEY_PITCH_UP:   pitch_trim   = step_trim(pitch_trim, int'(trim_step));
            KEY_PITCH_DOWN: pitch_trim   = step_trim(pitch_trim, -int'(trim_step));
            KEY_ROLL_RIGHT: roll_trim    = step_trim(roll_trim, int'(trim_step));
            KEY_ROLL_LEFT:  roll_trim    = step_trim(roll_trim, -int'(trim_step));
            KEY_SHUTDOWN:   shutdown_req = 1'b1;
            KEY_HOLD:       hold_mode    = ~hold_mode;
            default: ;
        endcase
        c.shutdown_flag = shutdown_req;
        c.hold_flag     = hold_mode;
        expected_commands.push_back(c);
    endfunction

    function void check_command(rsp_t got);
        rsp_t exp;
        if (expected_commands.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("response with no request outstanding");
            return;
        end
        exp = expected_commands.pop_front();
        compare("pitch_out", exp.pitch_out, got.pitch_out);
        compare("roll_out", exp.roll_out, got.roll_out);
        compare("yaw_out", exp.yaw_out, got.yaw_out);
        compare("throttle_out", exp.throttle_out, got.throttle_out);
        compare("shutdown_flag", exp.shutdown_flag, got.shutdown_flag);
        compare("hold_flag", exp.hold_flag, got.hold_flag);
    endfunction
endclass

module tb;
    localparam int    ITEMS_PER_PHASE = 265;
    localparam int    WATCHDOG_LIMIT  = 2000;
    localparam addr_t TRIM_STEP_ADDR  = addr_t'(4 * int'(REG_TRIM_STEP));

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req_data;
    logic  res_valid;
    logic  res_ready;
    rsp_t  res_data;
    logic  psel;
    logic  penable;
    logic  pwrite;
    addr_t paddr;
    data_t pwdata;
    data_t prdata;
    logic  pready;

    logic  tx_idle;
    logic  rx_idle;
    key_t  burst_key;
    int    burst_left;
    int    stalled;

    command_checker cmd_sb;

    stick_condition_with_trim_calibration_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            cmd_sb.take_request(req_data);
        if (rst_n && res_valid && res_ready)
            cmd_sb.check_command(res_data);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic raw_t random_raw();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll == 2)
            return raw_t'($urandom_range(1900, 2200));
        return raw_t'($urandom_range(0, 4095));
    endfunction

    // Trim keys often come in long runs so that the trims reach their limits.
    function automatic key_t random_key();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return burst_key;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            burst_key  = key_t'($urandom_range(KEY_PITCH_UP, KEY_ROLL_LEFT));
            burst_left = $urandom_range(4, 24);
            return burst_key;
        end
        if (roll < 45)
            return KEY_NONE;
        if (roll < 52)
            return KEY_CALIBRATE;
        if (roll < 68)
            return key_t'($urandom_range(KEY_PITCH_UP, KEY_ROLL_LEFT));
        if (roll < 80)
            return KEY_SHUTDOWN;
        if (roll < 92)
            return KEY_HOLD;
        return key_t'($urandom_range(0, 7));
    endfunction

    function automatic req_t random_request();
        logic [63:0] bits;
        req_t        r;
        if ($urandom_range(0, 99) < 15)
        begin
            bits = {$urandom(), $urandom()};
            r = bits[$bits(req_t)-1:0];
        end
        else
        begin
            r.raw_pitch    = random_raw();
            r.raw_roll     = random_raw();
            r.raw_yaw      = random_raw();
            r.raw_throttle = random_raw();
            r.key_code     = random_key();
            r.tx_acked     = ($urandom_range(0, 3) == 0);
        end
        return r;
    endfunction

    function automatic req_t make_req(raw_t p, raw_t r, raw_t y, raw_t t, key_t k, logic a);
        req_t q;
        q.raw_pitch    = p;
        q.raw_roll     = r;
        q.raw_yaw      = y;
        q.raw_throttle = t;
        q.key_code     = k;
        q.tx_acked     = a;
        return q;
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_request(req_t r);
        int gap;
        req_data  = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid = 1'b0;
        while (cmd_sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_trim_step(step_t s);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = TRIM_STEP_ADDR;
        pwdata  = data_t'(s);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        cmd_sb.compare("trim_step readback", int'(s), int'(prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        cmd_sb.set_trim_step(s);
    endtask

    initial
    begin
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready) || psel)
                stalled = 0;
            else
                stalled++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        forever
        begin
            repeat ($urandom_range(1, 24))
            begin
                @(negedge clk);
                res_ready = 1'b1;
            end
            repeat (rx_idle ? pick_gap() : 0)
            begin
                @(negedge clk);
                res_ready = 1'b0;
            end
        end
    end

    initial
    begin
        step_t step_values[6];
        int    p;
        int    i;
        cmd_sb     = new();
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        res_ready  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        burst_key  = KEY_NONE;
        burst_left = 0;
        step_values[0] = 6'd50;
        step_values[1] = 6'd1;
        step_values[2] = 6'd0;
        step_values[3] = 6'd63;
        step_values[4] = TRIM_STEP_RESET;
        step_values[5] = step_t'($urandom_range(0, 63));
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(make_req(12'h000, 12'h000, 12'h000, 12'h000, KEY_NONE, 1'b0));
        send_request(make_req(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, KEY_NONE, 1'b0));
        send_request(make_req(12'hAAA, 12'h555, 12'hAAA, 12'h555, KEY_NONE, 1'b1));
        send_request(make_req(12'h555, 12'hAAA, 12'h555, 12'hAAA, KEY_NONE, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'hFFF, KEY_CALIBRATE, 1'b0));
        send_request(make_req(12'h000, 12'h000, 12'h000, 12'h000, KEY_NONE, 1'b0));
        send_request(make_req(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, KEY_NONE, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd0, KEY_PITCH_UP, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd0, KEY_PITCH_UP, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd0, KEY_PITCH_DOWN, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd0, KEY_ROLL_RIGHT, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd0, KEY_ROLL_LEFT, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd0, KEY_ROLL_LEFT, 1'b0));
        send_request(make_req(12'd100, 12'd200, 12'd300, 12'd400, KEY_SHUTDOWN, 1'b0));
        send_request(make_req(12'd100, 12'd200, 12'd300, 12'd400, KEY_NONE, 1'b0));
        send_request(make_req(12'd100, 12'd200, 12'd300, 12'd400, KEY_SHUTDOWN, 1'b1));
        send_request(make_req(12'd100, 12'd200, 12'd300, 12'd400, KEY_NONE, 1'b1));
        send_request(make_req(12'd3000, 12'd1000, 12'd50, 12'd4000, KEY_HOLD, 1'b0));
        send_request(make_req(12'd3000, 12'd1000, 12'd50, 12'd4000, KEY_HOLD, 1'b0));
        send_request(make_req(12'd3000, 12'd1000, 12'd50, 12'd4000, KEY_HOLD, 1'b1));
        send_request(make_req(12'h000, 12'h000, 12'h000, 12'h000, KEY_CALIBRATE, 1'b0));
        send_request(make_req(12'h000, 12'h000, 12'h000, 12'h000, KEY_NONE, 1'b0));
        send_request(make_req(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, KEY_CALIBRATE, 1'b0));
        send_request(make_req(12'd2048, 12'd2048, 12'd2048, 12'd2048, KEY_NONE, 1'b0));

        for (p = 0; p < 6; p++)
        begin
            wait_drained();
            write_trim_step(step_values[p]);
            tx_idle = (p == 1) || (p >= 3);
            rx_idle = (p == 2) || (p >= 3);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_request(random_request());
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (cmd_sb.mismatches == 0 && cmd_sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
